// ===== sv/sem_pkg.sv =====
// Shared types, widths and constants of the Sobel edge-magnitude block.
package sem_pkg;

  localparam int MAX_LINE_WIDTH_DEF = 1024;
  localparam int PIXEL_BITS_DEF     = 8;

  localparam int MAG_W      = 11;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;
  localparam int IMG_H_MAX  = 4096;
  localparam int DIM_MIN    = 3;
  localparam int DIM_RESET  = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 4'd0,
    REG_IMAGE_HEIGHT = 4'd1
  } cfg_reg_e;

  // Sobel kernels, indexed [line][column], line 0 is the oldest line
  localparam int KERN_X [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
  localparam int KERN_Y [3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};

  // Position data that travels with each result through the pipeline
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } meta_t;

endpackage

// ===== sv/sem_pix_if.sv =====
// Pixel input channel: valid/ready handshake with one pixel per word.
interface sem_pix_if import sem_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// ===== sv/sem_res_if.sv =====
// Result channel: valid/ready handshake carrying magnitude and position.
interface sem_res_if import sem_pkg::*;;
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic             last;

  modport source (output valid, output magnitude, output row, output col, output last,
                  input ready);
  modport sink   (input valid, input magnitude, input row, input col, input last,
                  output ready);
endinterface

// ===== sv/sem_cfg_if.sv =====
// Configuration write channel: valid/ready handshake with register index and data.
interface sem_cfg_if import sem_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/sem_line_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sem_line_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/sem_sqrt_cell.sv =====
// One cell of the square-root chain: resolves one root bit per word.
module sem_sqrt_cell import sem_pkg::*; #(
  parameter int NB = 11
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  meta_t           meta_i,
  input  logic [2*NB-1:0] rad_i,
  input  logic [NB+1:0]   rem_i,
  input  logic [NB-1:0]   root_i,
  output logic            vld_o,
  output meta_t           meta_o,
  output logic [2*NB-1:0] rad_o,
  output logic [NB+1:0]   rem_o,
  output logic [NB-1:0]   root_o
);

  localparam int RAD_W = 2 * NB;
  localparam int RW    = NB + 2;

  logic              vld_r;
  meta_t             meta_r;
  logic [RAD_W-1:0]  rad_r;
  logic [RW-1:0]     rem_r;
  logic [NB-1:0]     root_r;

  logic [RW+1:0]     rem_sh;
  logic [RW+1:0]     trial;
  logic [RW+1:0]     diff;
  logic              ge;
  logic [RW-1:0]     rem_nxt;
  logic [NB-1:0]     root_nxt;
  logic [RAD_W-1:0]  rad_nxt;

  // bring down the next two radicand bits and try root*4+1
  always_comb begin
    rem_sh   = {rem_i, rad_i[RAD_W-1 -: 2]};
    trial    = (RW+2)'({root_i, 2'b01});
    diff     = rem_sh - trial;
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? diff[RW-1:0] : rem_sh[RW-1:0];
    root_nxt = {root_i[NB-2:0], ge};
    rad_nxt  = {rad_i[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r <= meta_i;
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign meta_o = meta_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

// ===== sv/sobel_edge_magnitude_unit.sv =====
// Sobel 3x3 edge-magnitude unit: line stores, window, gradient and square-root chain.
//
// Pixels enter on in_ch in raster order, one per accepted word. For every pixel
// whose 3x3 neighborhood lies inside the frame, one word leaves on out_ch with
// floor(sqrt(gx^2 + gy^2)), the row and column of the centre pixel, and last set
// on the final interior result of the frame. Border pixels give no word.
// cfg_ch writes image_width (index 0) and image_height (index 1); values are
// clamped into 3..MAX_LINE_WIDTH and 3..4096. cfg_ch is always ready; write it
// only while no pixel is in flight.
// Throughput: one pixel per clock while out_ch is not stalled. After its pixel is
// accepted, a result passes one line-store read, window shift, kernel sums,
// squares, PIXEL_BITS + 3 square-root cells and the output register.
// The square-root chain resolves one root bit per cell, so its length sets
// the latency.
// When out_ch is stalled with a word held, the whole pipeline freezes and in_ch
// drops ready until the word is taken.
// Reset (rst_n low, synchronous) empties the pipeline, zeros the counters and
// window and sets both dimensions to 8. Line store contents are not cleared;
// every entry is written one line before it is read.
module sobel_edge_magnitude_unit import sem_pkg::*; #(
  parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF,
  parameter int PIXEL_BITS     = PIXEL_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sem_pix_if.sink   in_ch,
  sem_res_if.source out_ch,
  sem_cfg_if.sink   cfg_ch
);

  localparam int CW     = $clog2(MAX_LINE_WIDTH);
  localparam int EW     = $clog2(MAX_LINE_WIDTH + 1);
  localparam int WW     = (EW > IMG_W_W) ? EW : IMG_W_W;
  localparam int GW     = PIXEL_BITS + 3;
  localparam int AW     = PIXEL_BITS + 2;
  localparam int SW     = 2 * AW + 1;
  localparam int NB     = AW + 1;
  localparam int RAD_W  = 2 * NB;
  localparam int RW     = NB + 2;
  localparam int W_RST  = (DIM_RESET > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : DIM_RESET;

  // ---------------- configuration ----------------
  logic [WW-1:0]      eff_w_r;
  logic [IMG_H_W-1:0] eff_h_r;
  logic [WW-1:0]      w_in;
  logic [WW-1:0]      w_clamp;
  logic [IMG_H_W-1:0] h_in;
  logic [IMG_H_W-1:0] h_clamp;

  always_comb begin
    w_in    = WW'(cfg_ch.data[IMG_W_W-1:0]);
    h_in    = cfg_ch.data[IMG_H_W-1:0];
    w_clamp = w_in;
    if (w_in < WW'(DIM_MIN)) begin
      w_clamp = WW'(DIM_MIN);
    end else if (w_in > WW'(MAX_LINE_WIDTH)) begin
      w_clamp = WW'(MAX_LINE_WIDTH);
    end
    h_clamp = h_in;
    if (h_in < IMG_H_W'(DIM_MIN)) begin
      h_clamp = IMG_H_W'(DIM_MIN);
    end else if (h_in > IMG_H_W'(IMG_H_MAX)) begin
      h_clamp = IMG_H_W'(IMG_H_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= WW'(W_RST);
      eff_h_r <= IMG_H_W'(DIM_RESET);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_IMAGE_WIDTH:  eff_w_r <= w_clamp;
        REG_IMAGE_HEIGHT: eff_h_r <= h_clamp;
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // ---------------- pipeline control ----------------
  logic out_valid_r;
  logic adv;
  logic in_acc;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_acc      = in_ch.valid && adv;

  // ---------------- position counters ----------------
  logic [CW-1:0]    col_count_r;
  logic [CW-1:0]    col_count_nxt;
  logic [ROW_W-1:0] row_count_r;
  logic [ROW_W-1:0] row_count_nxt;
  logic             interior;
  meta_t            meta_in;

  always_comb begin
    col_count_nxt = col_count_r + CW'(1);
    row_count_nxt = row_count_r;
    if (WW'(col_count_r) + WW'(1) >= eff_w_r) begin
      col_count_nxt = '0;
      if (IMG_H_W'(row_count_r) + IMG_H_W'(1) >= eff_h_r) begin
        row_count_nxt = '0;
      end else begin
        row_count_nxt = row_count_r + ROW_W'(1);
      end
    end
    interior     = (row_count_r >= ROW_W'(2)) && (CW'(col_count_r) >= CW'(2));
    meta_in.row  = row_count_r - ROW_W'(1);
    meta_in.col  = COL_W'(col_count_r - CW'(1));
    meta_in.last = (IMG_H_W'(row_count_r) == eff_h_r - IMG_H_W'(1)) &&
                   (WW'(col_count_r) == eff_w_r - WW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (in_acc) begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  // ---------------- stage A: line store read ----------------
  logic                  a_vld_r;
  logic                  a_interior_r;
  meta_t                 meta_a_r;
  logic [CW-1:0]         col_a_r;
  logic [PIXEL_BITS-1:0] px_a_r;
  logic [PIXEL_BITS-1:0] top_px;
  logic [PIXEL_BITS-1:0] mid_px;
  logic                  ls_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_interior_r <= interior;
      meta_a_r     <= meta_in;
      col_a_r      <= col_count_r;
      px_a_r       <= in_ch.pixel;
    end
  end

  assign ls_we = a_vld_r && adv;

  // line store A holds the previous line, B the line before it
  sem_line_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_store_a (
    .clk   (clk),
    .we    (ls_we),
    .waddr (col_a_r),
    .wdata (px_a_r),
    .re    (in_acc),
    .raddr (col_count_r),
    .rdata (mid_px)
  );

  sem_line_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_store_b (
    .clk   (clk),
    .we    (ls_we),
    .waddr (col_a_r),
    .wdata (mid_px),
    .re    (in_acc),
    .raddr (col_count_r),
    .rdata (top_px)
  );

  // ---------------- 3x3 window, stage B ----------------
  logic [PIXEL_BITS-1:0] win_r [3][3];
  logic                  b_vld_r;
  meta_t                 meta_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (ls_we) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= top_px;
      win_r[1][2] <= mid_px;
      win_r[2][2] <= px_a_r;
    end
  end

  // drop border pixels here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r && a_interior_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_b_r <= meta_a_r;
    end
  end

  // ---------------- stage C: kernel sums ----------------
  logic signed [GW-1:0] sx;
  logic signed [GW-1:0] sy;
  logic signed [GW-1:0] px_s;
  logic [AW-1:0]        ax_nxt;
  logic [AW-1:0]        ay_nxt;
  logic                 c_vld_r;
  meta_t                meta_c_r;
  logic [AW-1:0]        ax_r;
  logic [AW-1:0]        ay_r;

  always_comb begin
    sx   = '0;
    sy   = '0;
    px_s = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        px_s = signed'(GW'(win_r[i][j]));
        sx   = sx + px_s * GW'(KERN_X[i][j]);
        sy   = sy + px_s * GW'(KERN_Y[i][j]);
      end
    end
    ax_nxt = sx[GW-1] ? AW'(-sx) : AW'(sx);
    ay_nxt = sy[GW-1] ? AW'(-sy) : AW'(sy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_c_r <= meta_b_r;
      ax_r     <= ax_nxt;
      ay_r     <= ay_nxt;
    end
  end

  // ---------------- stage D: sum of squares ----------------
  logic [2*AW-1:0] sq_x;
  logic [2*AW-1:0] sq_y;
  logic            d_vld_r;
  meta_t           meta_d_r;
  logic [SW-1:0]   sum_r;

  assign sq_x = ax_r * ax_r;
  assign sq_y = ay_r * ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_d_r <= meta_c_r;
      sum_r    <= SW'(sq_x) + SW'(sq_y);
    end
  end

  // ---------------- square-root chain ----------------
  logic             vld_w  [NB+1];
  meta_t            meta_w [NB+1];
  logic [RAD_W-1:0] rad_w  [NB+1];
  logic [RW-1:0]    rem_w  [NB+1];
  logic [NB-1:0]    root_w [NB+1];

  assign vld_w[0]  = d_vld_r;
  assign meta_w[0] = meta_d_r;
  assign rad_w[0]  = RAD_W'(sum_r);
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;

  for (genvar k = 0; k < NB; k++) begin : g_cell
    sem_sqrt_cell #(
      .NB (NB)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (vld_w[k]),
      .meta_i (meta_w[k]),
      .rad_i  (rad_w[k]),
      .rem_i  (rem_w[k]),
      .root_i (root_w[k]),
      .vld_o  (vld_w[k+1]),
      .meta_o (meta_w[k+1]),
      .rad_o  (rad_w[k+1]),
      .rem_o  (rem_w[k+1]),
      .root_o (root_w[k+1])
    );
  end

  // ---------------- output register ----------------
  logic [NB+MAG_W-1:0] root_ext;
  logic [MAG_W-1:0]    mag_nxt;
  logic [MAG_W-1:0]    mag_r;
  meta_t               meta_o_r;

  assign root_ext = (NB+MAG_W)'(root_w[NB]);
  assign mag_nxt  = (root_ext > (NB+MAG_W)'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_w[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r    <= mag_nxt;
      meta_o_r <= meta_w[NB];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.magnitude = mag_r;
  assign out_ch.row       = meta_o_r.row;
  assign out_ch.col       = meta_o_r.col;
  assign out_ch.last      = meta_o_r.last;

  // ---------------- assertions ----------------
  a_root_remainder : assert property (@(posedge clk) disable iff (!rst_n)
    vld_w[NB] |-> rem_w[NB] <= RW'({root_w[NB], 1'b0}))
    else $error("square-root remainder exceeds twice the root");

  a_stall_freeze : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(a_vld_r) && $stable(b_vld_r) && $stable(c_vld_r) &&
             $stable(d_vld_r) && $stable(sum_r) && $stable(col_count_r))
    else $error("pipeline moved while the output was stalled");

  a_last_interior : assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && meta_a_r.last) |-> a_interior_r)
    else $error("end-of-frame pixel not flagged as interior");

endmodule

// ===== tb/tb_sobel_edge_magnitude_unit.sv =====
// Testbench of the Sobel edge-magnitude unit: predicts every edge word and checks the result stream.
module tb_sobel_edge_magnitude_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sem_pkg::*;

  localparam int IDLE_PCT     = 12;
  localparam int LONG_STALL   = 300;
  localparam int LATENCY_TAIL = 2 * (PIXEL_BITS_DEF + 8);
  localparam int RANDOM_ITEMS = 1050;
  localparam int MAX_REPORTS  = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = '1;

  // bright corner, vertical step, flat white
  localparam logic [7:0] DIRECTED_PIX [27] = '{
    8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
    8'd0,   8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd0,   8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

  typedef enum int {TEXTURE_NOISE, TEXTURE_BINARY, TEXTURE_FLAT} texture_e;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } edge_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk    = 1'b0;
  logic rst_n  = 1'b0;
  logic steady = 1'b0;

  int unsigned stalls_asked = 0;
  int unsigned stalls_served = 0;
  int unsigned stall_left = 0;
  int unsigned pix_queued = 0;
  int unsigned pix_taken = 0;
  int unsigned cfg_queued = 0;
  int unsigned cfg_taken = 0;
  int unsigned edges_seen = 0;
  int unsigned fail_count = 0;

  logic [PIXEL_BITS_DEF-1:0] pixels_waiting [$];
  reg_write_t                writes_waiting [$];
  edge_word_t                edges_due [$];

  // predictor state
  logic [IMG_W_W-1:0]        width_reg;
  logic [IMG_H_W-1:0]        height_reg;
  logic [PIXEL_BITS_DEF-1:0] line_prev [MAX_LINE_WIDTH_DEF];
  logic [PIXEL_BITS_DEF-1:0] line_older [MAX_LINE_WIDTH_DEF];
  logic [PIXEL_BITS_DEF-1:0] win [3][3];
  int unsigned               row_pos;
  int unsigned               col_pos;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sem_pix_if pix_ch ();
  sem_res_if res_ch ();
  sem_cfg_if cfg_ch ();

  sobel_edge_magnitude_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_ch),
    .out_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  function automatic int unsigned active_width();
    if (width_reg < DIM_MIN) return DIM_MIN;
    if (width_reg > MAX_LINE_WIDTH_DEF) return MAX_LINE_WIDTH_DEF;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg < DIM_MIN) return DIM_MIN;
    if (height_reg > IMG_H_MAX) return IMG_H_MAX;
    return height_reg;
  endfunction

  function automatic logic [MAG_W-1:0] floor_root(int unsigned sum);
    logic [MAG_W-1:0] root;
    logic [MAG_W-1:0] trial;
    int               b;
    root = '0;
    for (b = MAG_W - 1; b >= 0; b--) begin
      trial = root | (MAG_W'(1) << b);
      if (trial * trial <= sum) root = trial;
    end
    return root;
  endfunction

  // Shift one pixel through line stores and window; queue the edge word it yields.
  function automatic void advance_sobel(logic [PIXEL_BITS_DEF-1:0] px);
    int unsigned               slot;
    logic [PIXEL_BITS_DEF-1:0] top;
    logic [PIXEL_BITS_DEF-1:0] mid;
    int                        gx;
    int                        gy;
    edge_word_t                word;
    slot = (col_pos < MAX_LINE_WIDTH_DEF) ? col_pos : MAX_LINE_WIDTH_DEF - 1;
    top = line_older[slot];
    mid = line_prev[slot];
    line_older[slot] = mid;
    line_prev[slot] = px;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px;
    if (row_pos >= 2 && col_pos >= 2) begin
      gx = 0;
      gy = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          gx += KERN_X[r][c] * int'(win[r][c]);
          gy += KERN_Y[r][c] * int'(win[r][c]);
        end
      end
      word.magnitude = floor_root(gx * gx + gy * gy);
      word.row = ROW_W'(row_pos - 1);
      word.col = COL_W'(col_pos - 1);
      word.last = (row_pos == active_height() - 1) && (col_pos == active_width() - 1);
      edges_due.push_back(word);
    end
    if (col_pos + 1 >= active_width()) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= active_height()) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // A column at or past the bound wraps after one more pixel.
  function automatic int unsigned pixels_to_frame_end();
    int unsigned w;
    int unsigned h;
    int unsigned this_row;
    int unsigned rows_after;
    w = active_width();
    h = active_height();
    this_row = (col_pos >= w) ? 1 : w - col_pos;
    rows_after = (row_pos + 1 >= h) ? 0 : h - 1 - row_pos;
    return this_row + rows_after * w;
  endfunction

  task automatic offer_pixel(logic [PIXEL_BITS_DEF-1:0] px);
    pixels_waiting.push_back(px);
    pix_queued++;
  endtask

  task automatic queue_pixels(int unsigned count, texture_e texture);
    logic [PIXEL_BITS_DEF-1:0] px;
    for (int unsigned i = 0; i < count; i++) begin
      case (texture)
        TEXTURE_BINARY: px = $urandom_range(1) ? 8'hFF : 8'h00;
        TEXTURE_FLAT:   px = 8'd100 + 8'($urandom_range(15));
        default:        px = 8'($urandom_range(255));
      endcase
      offer_pixel(px);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    writes_waiting.push_back(reg_write_t'{index: index, data: data});
    cfg_queued++;
    while (cfg_taken != cfg_queued) @(posedge clk);
  endtask

  // Wait until every pixel is taken and every edge word is back, then let the pipe empty.
  task automatic settle();
    while (pix_taken != pix_queued || edges_due.size() != 0) @(posedge clk);
    repeat (LATENCY_TAIL) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
      line_prev = '{default: '0};
      line_older = '{default: '0};
      win = '{default: '0};
      row_pos = 0;
      col_pos = 0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        advance_sobel(pix_ch.pixel);
        pix_taken++;
      end
      if (!pix_ch.valid || pix_ch.ready) begin
        if (pixels_waiting.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          pix_ch.valid <= 1'b1;
          pix_ch.pixel <= pixels_waiting.pop_front();
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch.valid <= 1'b0;
      width_reg = IMG_W_W'(DIM_RESET);
      height_reg = IMG_H_W'(DIM_RESET);
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_IMAGE_WIDTH:  width_reg = cfg_ch.data[IMG_W_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = cfg_ch.data[IMG_H_W-1:0];
          default: ;
        endcase
        cfg_taken++;
      end
      if (!cfg_ch.valid || cfg_ch.ready) begin
        if (writes_waiting.size() != 0) begin
          cfg_ch.valid <= 1'b1;
          {cfg_ch.index, cfg_ch.data} <= writes_waiting.pop_front();
        end else begin
          cfg_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: random back-pressure, plus a long hold on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stalls_served != stalls_asked) begin
      stalls_served <= stalls_asked;
      stall_left <= LONG_STALL;
      res_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_edges
    edge_word_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      edges_seen++;
      if (edges_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected edge word: mag %0d row %0d col %0d last %0b",
                   res_ch.magnitude, res_ch.row, res_ch.col, res_ch.last);
      end else begin
        want = edges_due.pop_front();
        if (res_ch.magnitude !== want.magnitude || res_ch.row !== want.row ||
            res_ch.col !== want.col || res_ch.last !== want.last) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("edge word %0d: expected mag %0d row %0d col %0d last %0b, got mag %0d row %0d col %0d last %0b",
                     edges_seen, want.magnitude, want.row, want.col, want.last,
                     res_ch.magnitude, res_ch.row, res_ch.col, res_ch.last);
        end
      end
    end
  end

  initial begin
    int unsigned random_items;
    int unsigned count;
    int unsigned rest;
    int unsigned span;
    int unsigned seen_mark;
    texture_e    texture;

    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // one frame at the reset size
    queue_pixels(DIM_RESET * DIM_RESET, TEXTURE_NOISE);
    settle();

    // sizes below the minimum clamp to 3x3
    write_reg(REG_IMAGE_WIDTH, 16'd1);
    write_reg(REG_IMAGE_HEIGHT, 16'd0);
    foreach (DIRECTED_PIX[i]) offer_pixel(DIRECTED_PIX[i]);
    settle();

    // a write past the register list changes nothing
    write_reg(CFG_IDX_SPARE, 16'hFFFF);
    queue_pixels(9, TEXTURE_BINARY);
    settle();

    // shrink mid-frame; counters past the new bound wrap on their next step
    write_reg(REG_IMAGE_WIDTH, 16'd7);
    write_reg(REG_IMAGE_HEIGHT, 16'd6);
    queue_pixels(3 * 7 + 5, TEXTURE_NOISE);
    settle();
    write_reg(REG_IMAGE_WIDTH, 16'd4);
    queue_pixels(1 + 4, TEXTURE_NOISE);
    settle();
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    queue_pixels(pixels_to_frame_end(), TEXTURE_NOISE);
    settle();

    // widest line, width field all ones; hold results so the input backs up
    steady <= 1'b1;
    write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    queue_pixels(MAX_LINE_WIDTH_DEF * DIM_MIN, TEXTURE_BINARY);
    seen_mark = edges_seen;
    while (edges_seen < seen_mark + 20) @(posedge clk);
    stalls_asked <= stalls_asked + 1;
    settle();
    steady <= 1'b0;

    // tallest frame, height field all ones
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    queue_pixels(DIM_MIN * IMG_H_MAX, TEXTURE_NOISE);
    settle();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      texture = texture_e'($urandom_range(2));
      if ($urandom_range(3) != 0) begin
        settle();
        span = ($urandom_range(9) == 0) ? $urandom_range(40, 3) : $urandom_range(12, 3);
        write_reg(REG_IMAGE_WIDTH, {5'($urandom), IMG_W_W'(span)});
        write_reg(REG_IMAGE_HEIGHT, {3'($urandom), IMG_H_W'($urandom_range(9, 3))});
      end
      if ($urandom_range(7) == 0) begin
        count = $urandom_range(active_width() * active_height() - 1, 1);
        queue_pixels(count, texture);
        settle();
        if ($urandom_range(1) == 0)
          write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(active_width(), 0)));
        else
          write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(active_height(), 0)));
        rest = pixels_to_frame_end();
        queue_pixels(rest, texture);
        random_items += count + rest;
      end else begin
        count = active_width() * active_height() * $urandom_range(3, 1);
        queue_pixels(count, texture);
        random_items += count;
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
